@@ src/cmp_pkg.sv @@
// ============================================================================
// cmp_pkg
// Shared types and constants for the CoAP message parser: result kinds,
// error codes, parse phases, the result record and the push bundle.
// ============================================================================
package cmp_pkg;

    localparam int BYTE_CNT_W  = 11;
    localparam int OPT_CNT_W   = 5;
    localparam int PAY_CNT_W   = 11;
    localparam int OPT_LEN_W   = 17;
    localparam int OFIFO_DEPTH = 8;
    localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);

    localparam logic [7:0]           MARKER    = 8'hFF;
    localparam logic [3:0]           EXT1      = 4'd13;
    localparam logic [3:0]           EXT2      = 4'd14;
    localparam logic [3:0]           RESERVED  = 4'd15;
    localparam logic [3:0]           MAX_TOKEN = 4'd8;
    localparam logic [OPT_LEN_W-1:0] EXT1_BIAS = 17'd13;
    localparam logic [OPT_LEN_W-1:0] EXT2_BIAS = 17'd269;

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_TOKEN   = 3'd1,
        KIND_OPT     = 3'd2,
        KIND_OPTBYTE = 3'd3,
        KIND_PAYLOAD = 3'd4,
        KIND_END     = 3'd5,
        KIND_ERROR   = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_SHORT_HEADER = 3'd1,
        ERR_TOKEN_LONG   = 3'd2,
        ERR_RESERVED     = 3'd3,
        ERR_TRUNCATED    = 3'd4
    } t_err;

    typedef enum logic [12:0] {
        PH_HDR      = 13'b0000000000001,
        PH_TOKEN    = 13'b0000000000010,
        PH_OPTHEAD  = 13'b0000000000100,
        PH_DELTA1   = 13'b0000000001000,
        PH_DELTA_HI = 13'b0000000010000,
        PH_DELTA_LO = 13'b0000000100000,
        PH_LEN1     = 13'b0000001000000,
        PH_LEN_HI   = 13'b0000010000000,
        PH_LEN_LO   = 13'b0000100000000,
        PH_VALUE    = 13'b0001000000000,
        PH_PAYLOAD  = 13'b0010000000000,
        PH_IGNORE   = 13'b0100000000000,
        PH_ERRSKIP  = 13'b1000000000000
    } t_phase;

    typedef struct packed {
        t_kind                 kind;
        logic [1:0]            version;
        logic [1:0]            msg_type;
        logic [3:0]            token_length;
        logic [7:0]            code;
        logic [15:0]           message_id;
        logic [15:0]           option_number;
        logic [OPT_LEN_W-1:0]  option_length;
        logic [7:0]            byte_out;
        logic [OPT_CNT_W-1:0]  option_count;
        logic [PAY_CNT_W-1:0]  payload_length;
        t_err                  error_code;
    } t_result;

    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

    function automatic t_result empty_result(input t_kind kind);
        t_result r;
        r            = '0;
        r.kind       = kind;
        r.error_code = ERR_NONE;
        return r;
    endfunction

endpackage

@@ src/cmp_parser.sv @@
// ============================================================================
// cmp_parser
// Per-byte CoAP parse step: header, token, options with extended forms,
// payload, end and error items. Produces up to two result items per byte.
// ============================================================================
module cmp_parser #(
    parameter int MAX_OPTIONS  = 10,
    parameter int MAX_DATAGRAM = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output cmp_pkg::t_push    o_push
);

    cmp_pkg::t_phase                      r_phase, n_phase;
    logic [cmp_pkg::BYTE_CNT_W-1:0]       r_byte_count, n_byte_count;
    logic [23:0]                          r_header_hold, n_header_hold;
    logic [3:0]                           r_token_remaining, n_token_remaining;
    logic [15:0]                          r_run_opt, n_run_opt;
    logic [cmp_pkg::OPT_LEN_W-1:0]        r_delta, n_delta;
    logic [cmp_pkg::OPT_LEN_W-1:0]        r_len, n_len;
    logic [cmp_pkg::OPT_LEN_W-1:0]        r_value_rem, n_value_rem;
    logic [cmp_pkg::OPT_CNT_W-1:0]        r_options_done, n_options_done;
    logic [cmp_pkg::PAY_CNT_W-1:0]        r_payload_seen, n_payload_seen;

    cmp_pkg::t_result c0, c1, fin;
    logic             c0_v, c1_v, fin_v;
    logic             after_d, start_o;

    always_comb begin
        n_phase           = r_phase;
        n_byte_count      = r_byte_count;
        n_header_hold     = r_header_hold;
        n_token_remaining = r_token_remaining;
        n_run_opt         = r_run_opt;
        n_delta           = r_delta;
        n_len             = r_len;
        n_value_rem       = r_value_rem;
        n_options_done    = r_options_done;
        n_payload_seen    = r_payload_seen;
        c0                = cmp_pkg::empty_result(cmp_pkg::KIND_HEADER);
        c0_v              = 1'b0;
        c1                = cmp_pkg::empty_result(cmp_pkg::KIND_ERROR);
        c1.error_code     = cmp_pkg::ERR_TOKEN_LONG;
        c1_v              = 1'b0;
        after_d           = 1'b0;
        start_o           = 1'b0;

        if (i_valid && (r_byte_count < cmp_pkg::BYTE_CNT_W'(MAX_DATAGRAM))) begin
            n_byte_count = r_byte_count + cmp_pkg::BYTE_CNT_W'(1);
            case (r_phase)
                cmp_pkg::PH_HDR: begin
                    case (r_byte_count[1:0])
                        2'd0: n_header_hold[23:16] = i_data_byte;
                        2'd1: n_header_hold[15:8]  = i_data_byte;
                        2'd2: n_header_hold[7:0]   = i_data_byte;
                        default: begin
                            c0              = cmp_pkg::empty_result(cmp_pkg::KIND_HEADER);
                            c0.version      = r_header_hold[23:22];
                            c0.msg_type     = r_header_hold[21:20];
                            c0.token_length = r_header_hold[19:16];
                            c0.code         = r_header_hold[15:8];
                            c0.message_id   = {r_header_hold[7:0], i_data_byte};
                            c0_v            = 1'b1;
                            if (r_header_hold[19:16] > cmp_pkg::MAX_TOKEN) begin
                                c1_v    = 1'b1;
                                n_phase = cmp_pkg::PH_ERRSKIP;
                            end else if (r_header_hold[19:16] == 4'd0) begin
                                n_phase = cmp_pkg::PH_OPTHEAD;
                            end else begin
                                n_token_remaining = r_header_hold[19:16];
                                n_phase           = cmp_pkg::PH_TOKEN;
                            end
                        end
                    endcase
                end
                cmp_pkg::PH_TOKEN: begin
                    c0                = cmp_pkg::empty_result(cmp_pkg::KIND_TOKEN);
                    c0.byte_out       = i_data_byte;
                    c0_v              = 1'b1;
                    n_token_remaining = r_token_remaining - 4'd1;
                    if (n_token_remaining == 4'd0) begin
                        n_phase = cmp_pkg::PH_OPTHEAD;
                    end
                end
                cmp_pkg::PH_OPTHEAD: begin
                    if (i_data_byte == cmp_pkg::MARKER) begin
                        n_phase = cmp_pkg::PH_PAYLOAD;
                    end else if (r_options_done >= cmp_pkg::OPT_CNT_W'(MAX_OPTIONS)) begin
                        n_phase = cmp_pkg::PH_IGNORE;
                    end else if ((i_data_byte[7:4] == cmp_pkg::RESERVED) ||
                                 (i_data_byte[3:0] == cmp_pkg::RESERVED)) begin
                        c0            = cmp_pkg::empty_result(cmp_pkg::KIND_ERROR);
                        c0.error_code = cmp_pkg::ERR_RESERVED;
                        c0_v          = 1'b1;
                        n_phase       = cmp_pkg::PH_ERRSKIP;
                    end else begin
                        n_delta = {13'd0, i_data_byte[7:4]};
                        n_len   = {13'd0, i_data_byte[3:0]};
                        if (i_data_byte[7:4] == cmp_pkg::EXT1) begin
                            n_phase = cmp_pkg::PH_DELTA1;
                        end else if (i_data_byte[7:4] == cmp_pkg::EXT2) begin
                            n_phase = cmp_pkg::PH_DELTA_HI;
                        end else begin
                            after_d = 1'b1;
                        end
                    end
                end
                cmp_pkg::PH_DELTA1: begin
                    n_delta = cmp_pkg::OPT_LEN_W'(i_data_byte) + cmp_pkg::EXT1_BIAS;
                    after_d = 1'b1;
                end
                cmp_pkg::PH_DELTA_HI: begin
                    n_delta = {1'b0, i_data_byte, 8'h00};
                    n_phase = cmp_pkg::PH_DELTA_LO;
                end
                cmp_pkg::PH_DELTA_LO: begin
                    n_delta = r_delta + cmp_pkg::OPT_LEN_W'(i_data_byte) + cmp_pkg::EXT2_BIAS;
                    after_d = 1'b1;
                end
                cmp_pkg::PH_LEN1: begin
                    n_len   = cmp_pkg::OPT_LEN_W'(i_data_byte) + cmp_pkg::EXT1_BIAS;
                    start_o = 1'b1;
                end
                cmp_pkg::PH_LEN_HI: begin
                    n_len   = {1'b0, i_data_byte, 8'h00};
                    n_phase = cmp_pkg::PH_LEN_LO;
                end
                cmp_pkg::PH_LEN_LO: begin
                    n_len   = r_len + cmp_pkg::OPT_LEN_W'(i_data_byte) + cmp_pkg::EXT2_BIAS;
                    start_o = 1'b1;
                end
                cmp_pkg::PH_VALUE: begin
                    c0          = cmp_pkg::empty_result(cmp_pkg::KIND_OPTBYTE);
                    c0.byte_out = i_data_byte;
                    c0_v        = 1'b1;
                    n_value_rem = r_value_rem - cmp_pkg::OPT_LEN_W'(1);
                    if (n_value_rem == '0) begin
                        n_options_done = r_options_done + cmp_pkg::OPT_CNT_W'(1);
                        n_phase        = cmp_pkg::PH_OPTHEAD;
                    end
                end
                cmp_pkg::PH_PAYLOAD: begin
                    c0          = cmp_pkg::empty_result(cmp_pkg::KIND_PAYLOAD);
                    c0.byte_out = i_data_byte;
                    c0_v        = 1'b1;
                    if (r_payload_seen != '1) begin
                        n_payload_seen = r_payload_seen + cmp_pkg::PAY_CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase

            if (after_d) begin
                if (n_len == cmp_pkg::OPT_LEN_W'(cmp_pkg::EXT1)) begin
                    n_phase = cmp_pkg::PH_LEN1;
                end else if (n_len == cmp_pkg::OPT_LEN_W'(cmp_pkg::EXT2)) begin
                    n_phase = cmp_pkg::PH_LEN_HI;
                end else begin
                    start_o = 1'b1;
                end
            end

            if (start_o) begin
                n_run_opt        = r_run_opt + n_delta[15:0];
                c0               = cmp_pkg::empty_result(cmp_pkg::KIND_OPT);
                c0.option_number = n_run_opt;
                c0.option_length = n_len;
                c0_v             = 1'b1;
                n_value_rem      = n_len;
                if (n_len == '0) begin
                    n_options_done = r_options_done + cmp_pkg::OPT_CNT_W'(1);
                    n_phase        = cmp_pkg::PH_OPTHEAD;
                end else begin
                    n_phase = cmp_pkg::PH_VALUE;
                end
            end
        end

        fin                = cmp_pkg::empty_result(cmp_pkg::KIND_END);
        fin.option_count   = n_options_done;
        fin.payload_length = n_payload_seen;
        fin_v              = i_valid && i_last_byte;
        case (n_phase)
            cmp_pkg::PH_HDR: begin
                fin            = cmp_pkg::empty_result(cmp_pkg::KIND_ERROR);
                fin.error_code = cmp_pkg::ERR_SHORT_HEADER;
            end
            cmp_pkg::PH_DELTA1, cmp_pkg::PH_DELTA_HI, cmp_pkg::PH_DELTA_LO,
            cmp_pkg::PH_LEN1, cmp_pkg::PH_LEN_HI, cmp_pkg::PH_LEN_LO,
            cmp_pkg::PH_VALUE: begin
                fin            = cmp_pkg::empty_result(cmp_pkg::KIND_ERROR);
                fin.error_code = cmp_pkg::ERR_TRUNCATED;
            end
            cmp_pkg::PH_ERRSKIP: begin
                fin_v = 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign o_push.v0 = c0_v || fin_v;
    assign o_push.v1 = c0_v && (c1_v || fin_v);
    assign o_push.r0 = c0_v ? c0 : fin;
    assign o_push.r1 = c1_v ? c1 : fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_last_byte)) begin
            r_phase           <= cmp_pkg::PH_HDR;
            r_byte_count      <= '0;
            r_header_hold     <= '0;
            r_token_remaining <= '0;
            r_run_opt         <= '0;
            r_delta           <= '0;
            r_len             <= '0;
            r_value_rem       <= '0;
            r_options_done    <= '0;
            r_payload_seen    <= '0;
        end else if (i_valid) begin
            r_phase           <= n_phase;
            r_byte_count      <= n_byte_count;
            r_header_hold     <= n_header_hold;
            r_token_remaining <= n_token_remaining;
            r_run_opt         <= n_run_opt;
            r_delta           <= n_delta;
            r_len             <= n_len;
            r_value_rem       <= n_value_rem;
            r_options_done    <= n_options_done;
            r_payload_seen    <= n_payload_seen;
        end
    end

`ifndef ASSERT_OFF
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_last_byte |=> r_phase == cmp_pkg::PH_HDR && r_byte_count == '0)
        else $error("parser state not cleared after final byte");

    a_opt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_options_done <= cmp_pkg::OPT_CNT_W'(MAX_OPTIONS))
        else $error("option count beyond limit");

    a_hdr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == cmp_pkg::PH_HDR |-> r_byte_count <= cmp_pkg::BYTE_CNT_W'(3))
        else $error("header phase past fourth byte");
`endif

endmodule

@@ src/cmp_ofifo.sv @@
// ============================================================================
// cmp_ofifo
// Result queue: takes up to two result items per cycle, hands out one.
// ============================================================================
module cmp_ofifo (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cmp_pkg::t_push            i_push,
    input  logic                      i_pop,
    output logic                      o_valid,
    output logic [cmp_pkg::OFIFO_AW:0] o_count,
    output cmp_pkg::t_result          o_data
);

    cmp_pkg::t_result                   r_mem [cmp_pkg::OFIFO_DEPTH];
    logic [cmp_pkg::OFIFO_AW-1:0]       r_wr_ptr, r_rd_ptr;
    logic [cmp_pkg::OFIFO_AW:0]         r_count;
    logic [cmp_pkg::OFIFO_AW-1:0]       wr_ptr1;
    logic [cmp_pkg::OFIFO_AW:0]         push_n;
    logic                               pop;

    assign wr_ptr1 = r_wr_ptr + cmp_pkg::OFIFO_AW'(1);
    assign push_n  = (cmp_pkg::OFIFO_AW+1)'(i_push.v0) + (cmp_pkg::OFIFO_AW+1)'(i_push.v1);
    assign pop     = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[wr_ptr1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + push_n[cmp_pkg::OFIFO_AW-1:0];
            r_rd_ptr <= r_rd_ptr + cmp_pkg::OFIFO_AW'(pop);
            r_count  <= r_count + push_n - (cmp_pkg::OFIFO_AW+1)'(pop);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (cmp_pkg::OFIFO_AW+1)'(cmp_pkg::OFIFO_DEPTH))
        else $error("result queue overflow");

    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v1 |-> i_push.v0)
        else $error("second result pushed without first");
`endif

endmodule

@@ src/coap_message_parser_top.sv @@
// ============================================================================
// coap_message_parser_top
// CoAP datagram parser, one byte per item in, parsed result items out.
// ============================================================================
// Input channel: i_valid / o_stall with i_data_byte and i_last_byte; a byte
// is taken at an edge where i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall with one result item per accepted edge
// (header, token byte, option start, option value byte, payload byte, end,
// error); fields not used by an item's kind are zero.
// An accepted byte passes through the input register and the parser into
// the result queue; its first result then leaves from the queue head.
// Throughput: one byte per cycle while o_stall is low. A byte yields zero,
// one or two results; the output side drains one per cycle from an 8-entry
// queue while i_stall is low, and o_stall rises when the queue cannot take
// two more results from the byte in the input register and the next one.
// Reset (synchronous, active low) empties the queue and returns the parser
// to the header phase. The final byte of each datagram does the same to the
// parser state. While i_stall is high the head result holds.
// ============================================================================
module coap_message_parser_top #(
    parameter int MAX_OPTIONS  = 10,
    parameter int MAX_DATAGRAM = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [1:0]  o_version,
    output logic [1:0]  o_msg_type,
    output logic [3:0]  o_token_length,
    output logic [7:0]  o_code,
    output logic [15:0] o_message_id,
    output logic [15:0] o_option_number,
    output logic [16:0] o_option_length,
    output logic [7:0]  o_byte_out,
    output logic [4:0]  o_option_count,
    output logic [10:0] o_payload_length,
    output logic [2:0]  o_error_code
);

    logic                        r_in_valid;
    logic [7:0]                  r_in_byte;
    logic                        r_in_last;
    logic                        in_acc;
    cmp_pkg::t_push              push;
    cmp_pkg::t_result            head;
    logic [cmp_pkg::OFIFO_AW:0]  fifo_count;

    assign o_stall = (fifo_count + (r_in_valid ? (cmp_pkg::OFIFO_AW+1)'(2)
                                               : (cmp_pkg::OFIFO_AW+1)'(0)))
                     > (cmp_pkg::OFIFO_AW+1)'(cmp_pkg::OFIFO_DEPTH - 2);
    assign in_acc  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    cmp_parser #(
        .MAX_OPTIONS  (MAX_OPTIONS),
        .MAX_DATAGRAM (MAX_DATAGRAM)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_push      (push)
    );

    cmp_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_valid && !i_stall),
        .o_valid (o_valid),
        .o_count (fifo_count),
        .o_data  (head)
    );

    assign o_kind           = head.kind;
    assign o_version        = head.version;
    assign o_msg_type       = head.msg_type;
    assign o_token_length   = head.token_length;
    assign o_code           = head.code;
    assign o_message_id     = head.message_id;
    assign o_option_number  = head.option_number;
    assign o_option_length  = head.option_length;
    assign o_byte_out       = head.byte_out;
    assign o_option_count   = head.option_count;
    assign o_payload_length = head.payload_length;
    assign o_error_code     = head.error_code;

endmodule
